@@ rtl/cdes_pkg.sv @@
// ----------------------------------------------------------------------------
// Civil date to epoch seconds: shared definitions
// Field widths, calendar constants and reciprocal constants for division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdes_pkg;

  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned MDAY_W   = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned ZONE_W   = 11;
  localparam int unsigned SEC_W    = 32;

  localparam logic [YEAR_W-1:0]  EPOCH_YEAR      = 12'd1970;
  localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
  localparam int unsigned LEAPS_BEFORE_EPOCH = 1969 / 4 - 1969 / 100 + 1969 / 400;

  // Days before the start of each month in a common year, and a full year.
  localparam logic [8:0] CUM_DAYS [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  // Exact reciprocals: v / 100 for 12-bit v, v / 15 for 30-bit v,
  // v / 225 for 28-bit v.
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_100_SHIFT = 19;
  localparam logic [30:0] RECIP_15 = 31'd1145324613;
  localparam int unsigned RECIP_15_SHIFT = 34;
  localparam logic [28:0] RECIP_225 = 29'd305419897;
  localparam int unsigned RECIP_225_SHIFT = 36;

  localparam logic [SEC_W-1:0] SECS_PER_MINUTE = 32'd60;
  localparam logic [SEC_W-1:0] SECS_PER_HOUR   = 32'd3600;
  localparam logic [SEC_W-1:0] SECS_PER_DAY    = 32'd86400;

  typedef struct packed {
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

@@ rtl/civil_date_to_epoch_seconds_core.sv @@
// ----------------------------------------------------------------------------
// Civil date to epoch seconds
// Throughput: one beat per cycle while the output is not stalled.
// A stalled output holds only full stages.
// The six-stage pipeline runs from the input register to the result register.
// Reset clears all stage valid flags and sets the zone offset to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module civil_date_to_epoch_seconds_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cdes_pkg::ZONE_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cdes_pkg::YEAR_W-1:0]   year_i,
  input  logic [cdes_pkg::MONTH_W-1:0]  month_i,
  input  logic [cdes_pkg::MDAY_W-1:0]   day_of_month_i,
  input  logic [cdes_pkg::HOUR_W-1:0]   hour_i,
  input  logic [cdes_pkg::MINUTE_W-1:0] minute_i,
  input  logic                          summer_time_i,
  input  logic                          use_input_minutes_i,
  input  logic [cdes_pkg::SEC_W-1:0]    current_seconds_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cdes_pkg::SEC_W-1:0]    new_epoch_seconds_o
);
  import cdes_pkg::*;

  logic [ZONE_W-1:0] zone_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;
  stage_en_t day_en;

  // Stage 1: input register.
  logic [YEAR_W-1:0]   year1_q;
  logic [MONTH_W-1:0]  month1_q;
  logic [MDAY_W-1:0]   mday1_q;
  logic [HOUR_W-1:0]   hour1_q;
  logic [MINUTE_W-1:0] minute1_q;
  logic                dst1_q, keep1_q;
  logic [SEC_W-1:0]    now1_q;

  // Stage 2.
  logic [56:0]         prod_now;
  logic [HOUR_W-1:0]   hour2_q;
  logic [MINUTE_W-1:0] minute2_q;
  logic                dst2_q, keep2_q;
  logic [20:0]         nowq2_q;
  logic [11:0]         nowlo2_q;

  // Stage 3.
  logic [SEC_W-1:0]    adj3_d;
  logic [SEC_W-1:0]    adj3_q;
  logic [SEC_W-1:0]    nowq_x3600;
  logic [11:0]         rem3_d;
  logic [11:0]         rem3_q;
  logic                keep3_q;
  logic [SEC_W-1:0]    days3;

  // Stage 4.
  logic [SEC_W-1:0]    t4_d;
  logic [SEC_W-1:0]    t4_q;
  logic [11:0]         rem4_q;
  logic                keep4_q;

  // Stage 5.
  logic [29:0]         div_op;
  logic [30:0]         div_recip;
  logic [60:0]         prod_t;
  logic [26:0]         q5_d;
  logic [26:0]         q5_q;
  logic [11:0]         rem5_q;
  logic                keep5_q;

  // Stage 6: result register.
  logic [SEC_W-1:0]    q5_ext;
  logic [SEC_W-1:0]    res6_d;
  logic [SEC_W-1:0]    res6_q;

  always_comb begin
    en6 = !v6_q || !out_stall_i;
    en5 = !v5_q || en6;
    en4 = !v4_q || en5;
    en3 = !v3_q || en4;
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
    day_en.s2 = en2;
    day_en.s3 = en3;
  end

  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        zone_q <= cfg_wdata_i;
      end
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      year1_q   <= year_i;
      month1_q  <= month_i;
      mday1_q   <= day_of_month_i;
      hour1_q   <= hour_i;
      minute1_q <= minute_i;
      dst1_q    <= summer_time_i;
      keep1_q   <= use_input_minutes_i;
      now1_q    <= current_seconds_i;
    end
  end

  cdes_day_count u_day_count (
    .clk_i   (clk_i),
    .en_i    (day_en),
    .year_i  (year1_q),
    .month_i (month1_q),
    .mday_i  (mday1_q),
    .days_o  (days3)
  );

  assign prod_now = 57'(now1_q[SEC_W-1:4]) * 57'(RECIP_225);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      hour2_q   <= hour1_q;
      minute2_q <= minute1_q;
      dst2_q    <= dst1_q;
      keep2_q   <= keep1_q;
      nowq2_q   <= prod_now[RECIP_225_SHIFT +: 21];
      nowlo2_q  <= now1_q[11:0];
    end
  end

  always_comb begin
    adj3_d = 32'(hour2_q) * SECS_PER_HOUR
           + 32'(minute2_q) * SECS_PER_MINUTE
           - (dst2_q ? SECS_PER_HOUR : 32'd0)
           + {{(SEC_W-ZONE_W){zone_q[ZONE_W-1]}}, zone_q} * SECS_PER_MINUTE;
    nowq_x3600 = 32'(nowq2_q) * SECS_PER_HOUR;
    rem3_d = nowlo2_q - nowq_x3600[11:0];
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      adj3_q  <= adj3_d;
      rem3_q  <= rem3_d;
      keep3_q <= keep2_q;
    end
  end

  assign t4_d = days3 * SECS_PER_DAY + adj3_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      t4_q    <= t4_d;
      rem4_q  <= rem3_q;
      keep4_q <= keep3_q;
    end
  end

  always_comb begin
    div_op    = keep4_q ? t4_q[SEC_W-1:2] : 30'(t4_q[SEC_W-1:4]);
    div_recip = keep4_q ? RECIP_15 : 31'(RECIP_225);
    prod_t    = 61'(div_op) * 61'(div_recip);
    q5_d      = keep4_q ? prod_t[RECIP_15_SHIFT +: 27]
                        : 27'(prod_t[60:RECIP_225_SHIFT]);
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      q5_q    <= q5_d;
      rem5_q  <= rem4_q;
      keep5_q <= keep4_q;
    end
  end

  always_comb begin
    q5_ext = 32'(q5_q);
    res6_d = keep5_q ? ((q5_ext << 6) - (q5_ext << 2))
                     : (q5_ext * SECS_PER_HOUR + 32'(rem5_q));
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      res6_q <= res6_d;
    end
  end

  assign out_valid_o         = v6_q;
  assign new_epoch_seconds_o = res6_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q && v6_q))
    else $error("input stalled while a pipeline stage is empty");

  a_now_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (rem3_q < 12'd3600))
    else $error("clock seconds remainder out of range");

  a_hour_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && !keep5_q) |-> (q5_q < 27'd1193047))
    else $error("hour quotient out of range");

endmodule

@@ rtl/cdes_day_count.sv @@
// ----------------------------------------------------------------------------
// Civil date to epoch seconds: day count
// Two pipeline stages that turn a Gregorian date into days since 1970.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdes_day_count (
  input  logic                          clk_i,
  input  cdes_pkg::stage_en_t           en_i,
  input  logic [cdes_pkg::YEAR_W-1:0]   year_i,
  input  logic [cdes_pkg::MONTH_W-1:0]  month_i,
  input  logic [cdes_pkg::MDAY_W-1:0]   mday_i,
  output logic [cdes_pkg::SEC_W-1:0]    days_o
);
  import cdes_pkg::*;

  logic [YEAR_W-1:0]   y;
  logic [YEAR_W-1:0]   n;
  logic [24:0]         prod_n;
  logic [24:0]         prod_y;
  logic [YEAR_W-1:0]   y_q;
  logic [9:0]          n4_q;
  logic [5:0]          n100_q;
  logic [5:0]          y100_q;
  logic [MONTH_W-1:0]  month_q;
  logic [MDAY_W-1:0]   mday_q;

  logic [YEAR_W-1:0]   y100_x100;
  logic                leap;
  logic [MONTH_W-1:0]  mc;
  logic [YEAR_W-1:0]   yoff;
  logic [SEC_W-1:0]    days_d;
  logic [SEC_W-1:0]    days_q;

  always_comb begin
    y      = (year_i < EPOCH_YEAR) ? EPOCH_YEAR : year_i;
    n      = y - 12'd1;
    prod_n = 25'(n) * 25'(RECIP_100);
    prod_y = 25'(y) * 25'(RECIP_100);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      y_q     <= y;
      n4_q    <= n[YEAR_W-1:2];
      n100_q  <= prod_n[RECIP_100_SHIFT +: 6];
      y100_q  <= prod_y[RECIP_100_SHIFT +: 6];
      month_q <= month_i;
      mday_q  <= mday_i;
    end
  end

  always_comb begin
    y100_x100 = 12'(y100_q) * 12'd100;
    leap = (y_q[1:0] == 2'd0) && ((y_q != y100_x100) || (y100_q[1:0] == 2'd0));
    mc   = (month_q > MONTHS_PER_YEAR) ? MONTHS_PER_YEAR : month_q;
    yoff = y_q - EPOCH_YEAR;
    days_d = 32'(yoff) * 32'd365
           + 32'(n4_q) - 32'(n100_q) + 32'(n100_q[5:2])
           - 32'(LEAPS_BEFORE_EPOCH)
           + 32'(CUM_DAYS[mc])
           + 32'(leap && (mc >= 4'd2))
           + 32'(mday_q) - 32'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      days_q <= days_d;
    end
  end

  assign days_o = days_q;

endmodule
